/* rtl/assert_macros.svh */
// Assertion macros shared by the selector RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define VMBF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define VMBF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/vmbf_pkg.sv */
// Types and constants of the video mode best-fit selector.
package vmbf_pkg;

  localparam int unsigned MAX_MODES_DEF = 256;

  localparam int unsigned NUM_W   = 16;
  localparam int unsigned RES_W   = 16;
  localparam int unsigned IDX_W   = 8;
  localparam int unsigned TDEP_W  = 6;
  localparam int unsigned DEPTH_W = 10;
  localparam int unsigned SQ_W    = 2 * RES_W;
  localparam int unsigned ERR_W   = SQ_W + 1;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned Q_CW    = $clog2(Q_DEPTH + 1);

  localparam int unsigned ATTR_SUPPORTED = 0;
  localparam int unsigned ATTR_GRAPHICS  = 4;
  localparam int unsigned ATTR_LINEAR    = 7;

  localparam logic [7:0] MODEL_DIRECT = 8'h06;
  localparam logic [7:0] MODEL_PACKED = 8'h04;
  localparam logic [7:0] MODEL_PLANAR = 8'h03;
  localparam logic [7:0] WIN_USABLE   = 8'h05;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_WIDTH   = 3'd0,
    CFG_TARGET_HEIGHT  = 3'd1,
    CFG_TARGET_DEPTH   = 3'd2,
    CFG_REQUESTED_MODE = 3'd3,
    CFG_FORCE_REQUEST  = 3'd4,
    CFG_SWAP_AXES      = 3'd5
  } cfg_index_t;

  typedef struct packed {
    logic [NUM_W-1:0]  mode_number;
    logic [15:0]       mode_attributes;
    logic [7:0]        window_attributes;
    logic [7:0]        memory_model;
    logic [RES_W-1:0]  x_resolution;
    logic [RES_W-1:0]  y_resolution;
    logic [7:0]        bits_per_pixel;
    logic [7:0]        red_bits;
    logic [7:0]        green_bits;
    logic [7:0]        blue_bits;
    logic              last_mode;
  } in_item_t;

  typedef struct packed {
    logic              found;
    logic [IDX_W-1:0]  chosen_index;
    logic [NUM_W-1:0]  chosen_mode;
    logic              by_request;
  } out_item_t;

  typedef struct packed {
    logic [RES_W-1:0]  target_width;
    logic [RES_W-1:0]  target_height;
    logic [TDEP_W-1:0] target_depth;
    logic [NUM_W-1:0]  requested_mode;
    logic              force_request;
    logic              swap_axes;
  } cfg_t;

  // Classified request as queued between front and back.
  typedef struct packed {
    logic                usable;
    logic                req_match;
    logic [IDX_W-1:0]    pos;
    logic [NUM_W-1:0]    number;
    logic                fits;
    logic [RES_W-1:0]    dx;
    logic [RES_W-1:0]    dy;
    logic [DEPTH_W-1:0]  gap;
    logic                last;
  } entry_t;

endpackage

/* rtl/vmbf_front.sv */
// Front end: accepts descriptors, counts list position and classifies each mode.
module vmbf_front #(
  parameter int unsigned MAX_MODES = vmbf_pkg::MAX_MODES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  vmbf_pkg::in_item_t in_data,
  input  vmbf_pkg::cfg_t    cfg,
  input  logic              q_full,
  output logic              q_push,
  output vmbf_pkg::entry_t  q_entry
);
  import vmbf_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_MODES + 1);

  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               in_range;
  logic               usable;
  logic               model_ok;
  logic [RES_W-1:0]   w, h;
  logic [DEPTH_W-1:0] depth, tdepth;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign in_range = cnt_r < CNT_W'(MAX_MODES);

  always_comb begin
    model_ok = (in_data.memory_model == MODEL_DIRECT) ||
               (in_data.memory_model == MODEL_PACKED) ||
               (in_data.memory_model == MODEL_PLANAR);
    usable = in_data.mode_attributes[ATTR_GRAPHICS] && model_ok &&
             (in_data.mode_attributes[ATTR_LINEAR] ||
              ((in_data.window_attributes & WIN_USABLE) == WIN_USABLE)) &&
             in_data.mode_attributes[ATTR_SUPPORTED];
    w = cfg.swap_axes ? in_data.y_resolution : in_data.x_resolution;
    h = cfg.swap_axes ? in_data.x_resolution : in_data.y_resolution;
    depth = (in_data.memory_model == MODEL_DIRECT)
          ? DEPTH_W'(in_data.red_bits) + DEPTH_W'(in_data.green_bits) +
            DEPTH_W'(in_data.blue_bits)
          : DEPTH_W'(in_data.bits_per_pixel);
    tdepth = DEPTH_W'(cfg.target_depth);

    q_entry.usable    = in_range && usable;
    q_entry.req_match = in_range && (cfg.requested_mode != '0) &&
                        (in_data.mode_number == cfg.requested_mode) &&
                        (usable || cfg.force_request);
    q_entry.pos       = IDX_W'(cnt_r);
    q_entry.number    = in_data.mode_number;
    q_entry.fits      = (w <= cfg.target_width) && (h <= cfg.target_height) &&
                        (depth >= tdepth);
    q_entry.dx        = (cfg.target_width >= w) ? cfg.target_width - w
                                                : w - cfg.target_width;
    q_entry.dy        = (cfg.target_height >= h) ? cfg.target_height - h
                                                 : h - cfg.target_height;
    q_entry.gap       = (tdepth >= depth) ? tdepth - depth : depth - tdepth;
    q_entry.last      = in_data.last_mode;
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (q_push) begin
      if (in_data.last_mode) begin
        cnt_nxt = '0;
      end else if (in_range) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* rtl/vmbf_queue.sv */
// Short queue of classified requests between front and back.
module vmbf_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  vmbf_pkg::entry_t push_entry,
  input  logic             pop,
  output logic             full,
  output logic             nonempty,
  output vmbf_pkg::entry_t head
);
  import vmbf_pkg::*;

  entry_t            mem [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0]   cnt_r, cnt_nxt;

  assign full     = cnt_r == Q_CW'(Q_DEPTH);
  assign nonempty = cnt_r != '0;
  assign head     = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + Q_AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + Q_AW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + Q_CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - Q_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

/* rtl/vmbf_back.sv */
// Back end: squares the size error, keeps the running best and the request hit, reports.
module vmbf_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_nonempty,
  input  vmbf_pkg::entry_t   q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output vmbf_pkg::out_item_t out_data,
  output logic               report
);
  import vmbf_pkg::*;

  // square stage
  logic               a_valid_r, a_valid_nxt;
  logic               a_usable_r, a_req_r, a_fits_r, a_last_r;
  logic [IDX_W-1:0]   a_pos_r;
  logic [NUM_W-1:0]   a_number_r;
  logic [DEPTH_W-1:0] a_gap_r;
  logic [SQ_W-1:0]    a_sqx_r, a_sqy_r;

  // list state
  logic               best_valid_r, best_fits_r;
  logic [IDX_W-1:0]   best_index_r;
  logic [NUM_W-1:0]   best_number_r;
  logic [ERR_W-1:0]   best_err_r;
  logic [DEPTH_W-1:0] best_gap_r;
  logic               req_hit_r;
  logic [IDX_W-1:0]   req_index_r;
  logic [NUM_W-1:0]   req_number_r;

  logic               best_valid_nxt, best_fits_nxt;
  logic [IDX_W-1:0]   best_index_nxt;
  logic [NUM_W-1:0]   best_number_nxt;
  logic [ERR_W-1:0]   best_err_nxt;
  logic [DEPTH_W-1:0] best_gap_nxt;
  logic               req_hit_nxt;
  logic [IDX_W-1:0]   req_index_nxt;
  logic [NUM_W-1:0]   req_number_nxt;

  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_r, out_nxt;

  logic               commit;
  logic [ERR_W-1:0]   err;
  logic               take;

  assign commit      = a_valid_r && !(a_last_r && out_valid_r && out_stall);
  assign q_pop       = q_nonempty && (!a_valid_r || commit);
  assign a_valid_nxt = q_pop || (a_valid_r && !commit);
  assign report      = commit && a_last_r;
  assign out_valid   = out_valid_r;
  assign out_data    = out_r;

  always_comb begin
    err = ERR_W'(a_sqx_r) + ERR_W'(a_sqy_r);
    if (!best_valid_r) begin
      take = 1'b1;
    end else if (a_fits_r != best_fits_r) begin
      take = a_fits_r;
    end else if (err != best_err_r) begin
      take = err < best_err_r;
    end else begin
      take = a_gap_r < best_gap_r;
    end
  end

  // state after this request, before the end-of-list clear
  always_comb begin
    best_valid_nxt  = best_valid_r;
    best_fits_nxt   = best_fits_r;
    best_index_nxt  = best_index_r;
    best_number_nxt = best_number_r;
    best_err_nxt    = best_err_r;
    best_gap_nxt    = best_gap_r;
    req_hit_nxt     = req_hit_r;
    req_index_nxt   = req_index_r;
    req_number_nxt  = req_number_r;
    if (a_req_r && !req_hit_r) begin
      req_hit_nxt    = 1'b1;
      req_index_nxt  = a_pos_r;
      req_number_nxt = a_number_r;
    end
    if (a_usable_r && take) begin
      best_valid_nxt  = 1'b1;
      best_fits_nxt   = a_fits_r;
      best_index_nxt  = a_pos_r;
      best_number_nxt = a_number_r;
      best_err_nxt    = err;
      best_gap_nxt    = a_gap_r;
    end
  end

  always_comb begin
    out_nxt = out_r;
    if (report) begin
      if (req_hit_nxt) begin
        out_nxt.found        = 1'b1;
        out_nxt.chosen_index = req_index_nxt;
        out_nxt.chosen_mode  = req_number_nxt;
        out_nxt.by_request   = 1'b1;
      end else if (best_valid_nxt) begin
        out_nxt.found        = 1'b1;
        out_nxt.chosen_index = best_index_nxt;
        out_nxt.chosen_mode  = best_number_nxt;
        out_nxt.by_request   = 1'b0;
      end else begin
        out_nxt = '0;
      end
    end
    out_valid_nxt = (out_valid_r && out_stall) || report;
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_usable_r <= q_head.usable;
      a_req_r    <= q_head.req_match;
      a_fits_r   <= q_head.fits;
      a_last_r   <= q_head.last;
      a_pos_r    <= q_head.pos;
      a_number_r <= q_head.number;
      a_gap_r    <= q_head.gap;
      a_sqx_r    <= SQ_W'(q_head.dx) * SQ_W'(q_head.dx);
      a_sqy_r    <= SQ_W'(q_head.dy) * SQ_W'(q_head.dy);
    end
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r     <= 1'b0;
      out_valid_r   <= 1'b0;
      best_valid_r  <= 1'b0;
      best_fits_r   <= 1'b0;
      best_index_r  <= '0;
      best_number_r <= '0;
      best_err_r    <= '0;
      best_gap_r    <= '0;
      req_hit_r     <= 1'b0;
      req_index_r   <= '0;
      req_number_r  <= '0;
    end else begin
      a_valid_r   <= a_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (report) begin
        best_valid_r  <= 1'b0;
        best_fits_r   <= 1'b0;
        best_index_r  <= '0;
        best_number_r <= '0;
        best_err_r    <= '0;
        best_gap_r    <= '0;
        req_hit_r     <= 1'b0;
        req_index_r   <= '0;
        req_number_r  <= '0;
      end else if (commit) begin
        best_valid_r  <= best_valid_nxt;
        best_fits_r   <= best_fits_nxt;
        best_index_r  <= best_index_nxt;
        best_number_r <= best_number_nxt;
        best_err_r    <= best_err_nxt;
        best_gap_r    <= best_gap_nxt;
        req_hit_r     <= req_hit_nxt;
        req_index_r   <= req_index_nxt;
        req_number_r  <= req_number_nxt;
      end
    end
  end

endmodule

/* rtl/video_mode_best_fit_selector_unit.sv */
// Top level of the video mode best-fit selector: registers, front, queue, back.
// One mode descriptor is taken per clock while input stall is low. The front
// classifies it in the cycle it is accepted and writes a two-deep queue; the back
// squares the size error in one stage and folds it into the running best in the
// next, so the sustained rate is one descriptor per cycle while no result is
// stalled. The choice for a list passes through the queue, the square stage and the
// output register after its last descriptor is accepted; input stall rises only when
// the queue is full behind a stalled result. Register writes are taken every cycle.
`include "assert_macros.svh"

module video_mode_best_fit_selector_unit #(
  parameter int unsigned MAX_MODES = vmbf_pkg::MAX_MODES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  vmbf_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output vmbf_pkg::out_item_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [vmbf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [vmbf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import vmbf_pkg::*;

  cfg_t   cfg_r, cfg_nxt;
  logic   q_push, q_pop, q_full, q_nonempty;
  entry_t q_entry, q_head;
  logic   report;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TARGET_WIDTH:   cfg_nxt.target_width   = cfg_data;
        CFG_TARGET_HEIGHT:  cfg_nxt.target_height  = cfg_data;
        CFG_TARGET_DEPTH:   cfg_nxt.target_depth   = cfg_data[TDEP_W-1:0];
        CFG_REQUESTED_MODE: cfg_nxt.requested_mode = cfg_data;
        CFG_FORCE_REQUEST:  cfg_nxt.force_request  = cfg_data[0];
        CFG_SWAP_AXES:      cfg_nxt.swap_axes      = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_width   <= RES_W'(640);
      cfg_r.target_height  <= RES_W'(480);
      cfg_r.target_depth   <= TDEP_W'(8);
      cfg_r.requested_mode <= '0;
      cfg_r.force_request  <= 1'b0;
      cfg_r.swap_axes      <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  vmbf_front #(
    .MAX_MODES (MAX_MODES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cfg      (cfg_r),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_entry)
  );

  vmbf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .full       (q_full),
    .nonempty   (q_nonempty),
    .head       (q_head)
  );

  vmbf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_nonempty (q_nonempty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .report     (report)
  );

  `VMBF_ASSERT_NOW(a_req_implies_found, clk, rst_n, out_valid && out_data.by_request, out_data.found, "request result without found")
  `VMBF_ASSERT_NOW(a_none_is_zero, clk, rst_n, out_valid && !out_data.found, (out_data.chosen_index == '0) && (out_data.chosen_mode == '0) && !out_data.by_request, "empty result not cleared")
  `VMBF_ASSERT_NEXT(a_result_from_report, clk, rst_n, !out_valid && !report, !out_valid, "result without end of list")

endmodule
